[rtl/carp_pkg.sv]
`default_nettype none

package carp_pkg;

  localparam int DATA_W   = 16;
  localparam int DIFF_W   = DATA_W + 1;
  localparam int INTEG_W  = 11;
  localparam int ISUM_W   = DIFF_W + 1;
  localparam int OPB_W    = 19;
  localparam int PROD_W   = DATA_W + OPB_W;
  localparam int ACC_W    = 52;
  localparam int TMP_W    = 36;
  localparam int SPLIT_W  = 18;
  localparam int FRAC_W   = 16;
  localparam int QUOT_W   = ACC_W - FRAC_W;
  localparam int DRIVE_W  = 14;
  localparam int NUM_REGS = 5;
  localparam int STEP_W   = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [ISUM_W-1:0] INTEG_LIMIT = ISUM_W'(1000);
  localparam logic signed [QUOT_W-1:0] DRIVE_LIMIT = QUOT_W'(4800);

  // register indexes, also used as the gain select of the microcode
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTER_PROP  = 3'd0,
    REG_OUTER_INTEG = 3'd1,
    REG_OUTER_DERIV = 3'd2,
    REG_INNER_PROP  = 3'd3,
    REG_INNER_DERIV = 3'd4
  } reg_idx_t;

  typedef logic [NUM_REGS-1:0][DATA_W-1:0] gain_vec_t;

  typedef enum logic [2:0] {
    OPB_ERR,
    OPB_INTEG,
    OPB_DANG,
    OPB_DRATE,
    OPB_TMP_LO,
    OPB_TMP_HI
  } opb_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_8,
    SH_18
  } shift_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_WAIT_OUT
  } jump_t;

  typedef struct packed {
    reg_idx_t gsel;
    opb_sel_t opb;
    acc_op_t  acc_op;
    shift_t   sh;
    logic     tmp_load;
    jump_t    jmp;
  } ucode_t;

  // control from the sequencer to the datapath, already qualified by handshakes
  typedef struct packed {
    reg_idx_t gsel;
    opb_sel_t opb;
    acc_op_t  acc_op;
    shift_t   sh;
    logic     tmp_load;
    logic     capture;
    logic     out_load;
  } ctrl_t;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(10);

  // control store
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{gsel: REG_OUTER_PROP, opb: OPB_ERR, acc_op: ACC_HOLD, sh: SH_0,
          tmp_load: 1'b0, jmp: JMP_NEXT};
    case (step)
      4'd0: begin
        w.jmp = JMP_WAIT_IN;
      end
      4'd1: begin
        w.gsel = REG_OUTER_PROP;  w.opb = OPB_ERR;
      end
      4'd2: begin
        w.gsel = REG_OUTER_INTEG; w.opb = OPB_INTEG;  w.acc_op = ACC_LOAD;
      end
      4'd3: begin
        w.gsel = REG_OUTER_DERIV; w.opb = OPB_DANG;   w.acc_op = ACC_ADD;
      end
      4'd4: begin
        w.acc_op = ACC_ADD;
      end
      4'd5: begin
        w.tmp_load = 1'b1;
      end
      4'd6: begin
        w.gsel = REG_INNER_PROP;  w.opb = OPB_TMP_LO;
      end
      4'd7: begin
        w.gsel = REG_INNER_PROP;  w.opb = OPB_TMP_HI; w.acc_op = ACC_LOAD;
      end
      4'd8: begin
        w.gsel = REG_INNER_DERIV; w.opb = OPB_DRATE;  w.acc_op = ACC_ADD; w.sh = SH_18;
      end
      4'd9: begin
        w.acc_op = ACC_ADD; w.sh = SH_8;
      end
      4'd10: begin
        w.jmp = JMP_WAIT_OUT;
      end
      default: begin
        w.jmp = JMP_NEXT;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/carp_seq.sv]
`default_nettype none

module carp_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            out_free,
  output carp_pkg::ctrl_t      ctrl,
  output logic                 in_ready
);
  import carp_pkg::*;

  logic [STEP_W-1:0] step_r, step_nxt;
  ucode_t            uw;

  assign uw = ucode_rom(step_r);

  always_comb begin
    step_nxt = step_r;
    case (uw.jmp)
      JMP_WAIT_IN: begin
        if (in_valid) step_nxt = step_r + 1'b1;
      end
      JMP_WAIT_OUT: begin
        if (out_free) step_nxt = '0;
      end
      JMP_NEXT: begin
        step_nxt = (step_r >= LAST_STEP) ? '0 : step_r + 1'b1;
      end
      default: begin
        step_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    in_ready      = (uw.jmp == JMP_WAIT_IN);
    ctrl.gsel     = uw.gsel;
    ctrl.opb      = uw.opb;
    ctrl.acc_op   = uw.acc_op;
    ctrl.sh       = uw.sh;
    ctrl.tmp_load = uw.tmp_load;
    ctrl.capture  = in_ready && in_valid;
    ctrl.out_load = (uw.jmp == JMP_WAIT_OUT) && out_free;
  end

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= LAST_STEP)
    else $error("step counter beyond program");

  a_load_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |=> in_ready)
    else $error("sequencer not back at wait after output load");

endmodule

`default_nettype wire

[rtl/carp_datapath.sv]
`default_nettype none

module carp_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire carp_pkg::ctrl_t                      ctrl,
  input  wire carp_pkg::gain_vec_t                  gains,
  input  wire logic signed [carp_pkg::DATA_W-1:0]   setpoint_angle,
  input  wire logic signed [carp_pkg::DATA_W-1:0]   gyro_rate,
  input  wire logic signed [carp_pkg::DATA_W-1:0]   measured_angle,
  output logic signed [carp_pkg::DRIVE_W-1:0]       drive
);
  import carp_pkg::*;

  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [DATA_W-1:0]  last_angle_r, last_rate_r;
  logic signed [DIFF_W-1:0]  err_r, dang_r, drate_r;
  logic signed [DIFF_W-1:0]  err_c, dang_c, drate_c;
  logic signed [ISUM_W-1:0]  isum;
  logic signed [DATA_W-1:0]  gain_c;
  logic signed [OPB_W-1:0]   opb_c;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, addend;
  logic signed [TMP_W-1:0]   tmp_r, rate768;
  logic signed [QUOT_W-1:0]  quot, quot_t;

  // differences and clamped integral, formed at capture
  always_comb begin
    err_c   = DIFF_W'(measured_angle) - DIFF_W'(setpoint_angle);
    dang_c  = DIFF_W'(measured_angle) - DIFF_W'(last_angle_r);
    drate_c = DIFF_W'(gyro_rate) - DIFF_W'(last_rate_r);
    isum    = ISUM_W'(integ_r) + ISUM_W'(err_c);
    if (isum > INTEG_LIMIT) begin
      integ_nxt = INTEG_W'(INTEG_LIMIT);
    end else if (isum < -INTEG_LIMIT) begin
      integ_nxt = INTEG_W'(-INTEG_LIMIT);
    end else begin
      integ_nxt = isum[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r      <= '0;
      last_angle_r <= '0;
      last_rate_r  <= '0;
    end else if (ctrl.capture) begin
      integ_r      <= integ_nxt;
      last_angle_r <= measured_angle;
      last_rate_r  <= gyro_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      err_r   <= err_c;
      dang_r  <= dang_c;
      drate_r <= drate_c;
    end
  end

  // shared multiplier operands
  always_comb begin
    case (ctrl.gsel)
      REG_OUTER_PROP:  gain_c = gains[REG_OUTER_PROP];
      REG_OUTER_INTEG: gain_c = gains[REG_OUTER_INTEG];
      REG_OUTER_DERIV: gain_c = gains[REG_OUTER_DERIV];
      REG_INNER_PROP:  gain_c = gains[REG_INNER_PROP];
      REG_INNER_DERIV: gain_c = gains[REG_INNER_DERIV];
      default:         gain_c = '0;
    endcase
    case (ctrl.opb)
      OPB_ERR:    opb_c = OPB_W'(err_r);
      OPB_INTEG:  opb_c = OPB_W'(integ_r);
      OPB_DANG:   opb_c = OPB_W'(dang_r);
      OPB_DRATE:  opb_c = OPB_W'(drate_r);
      OPB_TMP_LO: opb_c = {1'b0, tmp_r[SPLIT_W-1:0]};
      OPB_TMP_HI: opb_c = {tmp_r[TMP_W-1], tmp_r[TMP_W-1:SPLIT_W]};
      default:    opb_c = '0;
    endcase
    prod_nxt = PROD_W'(gain_c) * PROD_W'(opb_c);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // accumulator
  always_comb begin
    case (ctrl.sh)
      SH_0:    addend = ACC_W'(prod_r);
      SH_8:    addend = ACC_W'(prod_r) <<< 8;
      SH_18:   addend = ACC_W'(prod_r) <<< SPLIT_W;
      default: addend = ACC_W'(prod_r);
    endcase
  end

  always_ff @(posedge clk) begin
    case (ctrl.acc_op)
      ACC_LOAD: acc_r <= addend;
      ACC_ADD:  acc_r <= acc_r + addend;
      default:  acc_r <= acc_r;
    endcase
  end

  // inner input: outer output plus three times the rate, in q.8
  assign rate768 = (TMP_W'(last_rate_r) <<< 9) + (TMP_W'(last_rate_r) <<< 8);

  always_ff @(posedge clk) begin
    if (ctrl.tmp_load) begin
      tmp_r <= $signed(acc_r[TMP_W-1:0]) + rate768;
    end
  end

  // q.16 to integer, toward zero, then saturate
  always_comb begin
    quot   = $signed(acc_r[ACC_W-1:FRAC_W]);
    quot_t = quot + QUOT_W'(acc_r[ACC_W-1] && (acc_r[FRAC_W-1:0] != '0));
    if (quot_t > DRIVE_LIMIT) begin
      drive = DRIVE_W'(DRIVE_LIMIT);
    end else if (quot_t < -DRIVE_LIMIT) begin
      drive = DRIVE_W'(-DRIVE_LIMIT);
    end else begin
      drive = quot_t[DRIVE_W-1:0];
    end
  end

  a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
    (integ_r <= INTEG_W'(INTEG_LIMIT)) && (integ_r >= INTEG_W'(-INTEG_LIMIT)))
    else $error("integral out of clamp range");

endmodule

`default_nettype wire

[rtl/cascade_angle_rate_pid_top.sv]
// cascade angle/rate controller: outer pid on angle, inner pd on rate
// out_tvalid rises once the control program has run after the input beat is taken, later while a
//   beat waits; one input beat is in work at a time, run by the eleven-step control program
//   that feeds six partial products through one shared 16x19 multiplier
// reset (rst_n low, synchronous): gains, integral, last angle and last rate
//   cleared, program counter to its wait step, no output beat pending
`default_nettype none

module cascade_angle_rate_pid_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // config write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // setpoint_angle[15:0], gyro_rate[31:16],
                                       // measured_angle[47:32]
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // drive[13:0], zero pad[15:14]
);
  import carp_pkg::*;

  gain_vec_t                 gains_r;
  ctrl_t                     ctrl;
  logic                      out_free;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [DRIVE_W-1:0] drive_c, drive_r;

  // config writes are always taken; indexes past the list fall through
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OUTER_PROP:  gains_r[REG_OUTER_PROP]  <= cfg_data;
        REG_OUTER_INTEG: gains_r[REG_OUTER_INTEG] <= cfg_data;
        REG_OUTER_DERIV: gains_r[REG_OUTER_DERIV] <= cfg_data;
        REG_INNER_PROP:  gains_r[REG_INNER_PROP]  <= cfg_data;
        REG_INNER_DERIV: gains_r[REG_INNER_DERIV] <= cfg_data;
        default: begin
          gains_r <= gains_r;
        end
      endcase
    end
  end

  // output slot is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_tready;

  carp_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .ctrl     (ctrl),
    .in_ready (in_tready)
  );

  carp_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .gains          (gains_r),
    .setpoint_angle (in_tdata[15:0]),
    .gyro_rate      (in_tdata[31:16]),
    .measured_angle (in_tdata[47:32]),
    .drive          (drive_c)
  );

  // output register: holds the beat until the sink takes it, while the
  // sequencer is already free to take the next input beat
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      drive_r <= drive_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, drive_r};

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second input beat taken while one is in work");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (drive_r <= DRIVE_W'(4800)) && (drive_r >= DRIVE_W'(-4800)))
    else $error("drive outside saturation limits");

endmodule

`default_nettype wire

[bench/tb_cascade_angle_rate_pid_top.sv]
`default_nettype none

module tb_cascade_angle_rate_pid_top;
  import carp_pkg::*;

  // one control tick as it travels on in_tdata, lowest field last in the list
  typedef struct packed {
    logic signed [DATA_W-1:0] measured_angle;
    logic signed [DATA_W-1:0] gyro_rate;
    logic signed [DATA_W-1:0] setpoint_angle;
  } tick_t;

  // receiver behaviour, picked anew at random whenever its countdown runs out
  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_THIRDS,
    SINK_COIN,
    SINK_CHOKE
  } sink_mode_t;

  // indexes outside the register file, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_MID = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI  = CFG_IDX_W'(7);

  localparam logic [DATA_W-1:0] GAIN_MAX = 16'h7FFF;
  localparam logic [DATA_W-1:0] GAIN_MIN = 16'h8000;
  localparam logic [DATA_W-1:0] GAIN_ONE = 16'h0100;

  localparam longint INTEG_BOUND = 1000;
  localparam longint DRIVE_BOUND = 4800;
  localparam longint RATE_FEED_Q8 = 768;      // 3.0 in q.8
  localparam longint Q16_ONE = 65536;

  localparam int SETTLE_CYCLES = 4;           // idle margin before a register write
  localparam int END_CYCLES = 24;             // end margin after the last beat
  localparam int QUIET_LIMIT = 4000;          // cycles without any beat before giving up
  localparam int RAND_PHASES = 10;
  localparam int PHASE_TICKS = 160;

  logic clk;
  logic rst_n = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // setpoint_angle[15:0], gyro_rate[31:16], measured_angle[47:32]

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // drive[13:0], zero pad[15:14]

  cascade_angle_rate_pid_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // controller mirror: gains and loop state kept alongside the block
  // ---------------------------------------------------------------------------
  longint gain_q88 [NUM_REGS];
  longint integ_acc;
  longint prev_angle;
  longint prev_rate;

  // drive values still owed by the block, oldest first
  logic [DRIVE_W-1:0] pending_drive_q [$];

  int mismatches;
  int ticks_sent;
  int drives_checked;
  int gain_settings;
  int sink_left;
  sink_mode_t sink_mode;

  // sender pacing
  logic in_valid_set;
  int   burst_left;
  logic sender_steady;

  // slowly moving loop, so that the integral and derivatives see real trajectories
  int trk_set;
  int trk_ang;
  int trk_rate;

  initial begin
    for (int i = 0; i < NUM_REGS; i++) gain_q88[i] = 0;
    integ_acc = 0;
    prev_angle = 0;
    prev_rate = 0;
    mismatches = 0;
    ticks_sent = 0;
    drives_checked = 0;
    gain_settings = 0;
    in_valid_set = 1'b0;
    burst_left = 0;
    sender_steady = 1'b0;
    trk_set = 0;
    trk_ang = 0;
    trk_rate = 0;
  end

  function automatic longint sat(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // one control tick: updates the loop state and returns the saturated drive
  function automatic logic [DRIVE_W-1:0] next_drive(input tick_t t);
    longint sp, rate, ang, err, d_ang, d_rate, outer_q8, total_q16, drv;
    sp = longint'($signed(t.setpoint_angle));
    rate = longint'($signed(t.gyro_rate));
    ang = longint'($signed(t.measured_angle));
    err = ang - sp;
    d_ang = ang - prev_angle;
    d_rate = rate - prev_rate;
    // full error goes in before the clamp
    integ_acc = sat(integ_acc + err, INTEG_BOUND);
    outer_q8 = gain_q88[REG_OUTER_PROP] * err + gain_q88[REG_OUTER_INTEG] * integ_acc
             + gain_q88[REG_OUTER_DERIV] * d_ang;
    total_q16 = gain_q88[REG_INNER_PROP] * (outer_q8 + RATE_FEED_Q8 * rate)
              + 256 * gain_q88[REG_INNER_DERIV] * d_rate;
    prev_angle = ang;
    prev_rate = rate;
    // longint division truncates toward zero, then saturate rather than wrap
    drv = sat(total_q16 / Q16_ONE, DRIVE_BOUND);
    return drv[DRIVE_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // result side: stall pattern and checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_mode <= sink_mode_t'($urandom_range(3));
      sink_left <= $urandom_range(10, 80);
    end else begin
      sink_left <= sink_left - 1;
    end
    case (sink_mode)
      SINK_OPEN:   out_tready <= 1'b1;
      SINK_THIRDS: out_tready <= (sink_left % 3 == 0);
      SINK_COIN:   out_tready <= 1'($urandom_range(1));
      default:     out_tready <= (sink_left < 4);   // long stall with a short opening
    endcase
  end

  initial begin
    sink_left = 0;
    sink_mode = SINK_OPEN;
  end

  // every accepted drive beat is held against the oldest owed value
  always @(posedge clk) begin
    logic [DRIVE_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_drive_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] drive beat %0d with nothing owed", $realtime,
                   $signed(out_tdata[DRIVE_W-1:0]));
      end else begin
        want = pending_drive_q.pop_front();
        drives_checked++;
        if (out_tdata[DRIVE_W-1:0] !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] drive: expected %0d, got %0d", $realtime, $signed(want),
                     $signed(out_tdata[DRIVE_W-1:0]));
        end
        if (out_tdata[15:DRIVE_W] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] pad bits: expected 0, got %b", $realtime,
                     out_tdata[15:DRIVE_W]);
        end
      end
    end
  end

  // watchdog on cycles in which no channel moves a beat
  always @(posedge clk) begin
    int quiet;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("[%0t] no beat for %0d cycles, %0d drive values still owed", $realtime,
               quiet, pending_drive_q.size());
      $display("tb_cascade_angle_rate_pid_top: done, errors");
      $finish;
    end
  end

  initial begin
    // quiet counter starts from zero
  end

  // ---------------------------------------------------------------------------
  // sender and register helpers
  // ---------------------------------------------------------------------------
  task automatic lower_in_valid();
    if (in_valid_set) begin
      in_tvalid <= 1'b0;
      in_valid_set = 1'b0;
    end
  endtask

  // holds the tick until the block takes it, valid is left high for the next one
  task automatic send_tick(input tick_t t);
    in_tdata <= t;
    in_tvalid <= 1'b1;
    in_valid_set = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_drive_q.push_back(next_drive(t));
    ticks_sent++;
  endtask

  // bursts of random length, random gaps between them unless running steady
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if (!sender_steady) begin
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
          lower_in_valid();
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic send_paced(input tick_t t);
    send_tick(t);
    pace_sender();
  endtask

  // block is idle once every owed drive beat has come back
  task automatic wait_results_drained();
    lower_in_valid();
    while (pending_drive_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_REGS) gain_q88[idx] = longint'($signed(val));
  endtask

  task automatic load_gains(input gain_vec_t g);
    wait_results_drained();
    for (int i = 0; i < NUM_REGS; i++) cfg_write(CFG_IDX_W'(i), g[i]);
    cfg_valid <= 1'b0;
    gain_settings++;
  endtask

  function automatic tick_t make_tick(input int sp, input int rate, input int ang);
    tick_t t;
    t.setpoint_angle = DATA_W'(sp);
    t.gyro_rate = DATA_W'(rate);
    t.measured_angle = DATA_W'(ang);
    return t;
  endfunction

  function automatic tick_t random_tick();
    return make_tick(int'($urandom), int'($urandom), int'($urandom));
  endfunction

  // setpoint steps now and then, the angle chases it with some noise
  function automatic tick_t tracking_tick();
    int step;
    if ($urandom_range(15) == 0) trk_set = int'($urandom_range(4000)) - 2000;
    step = (trk_set - trk_ang) / 4 + int'($urandom_range(16)) - 8;
    trk_ang += step;
    trk_rate = step * 2 + int'($urandom_range(20)) - 10;
    return make_tick(trk_set, trk_rate, trk_ang);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // gains set before any tick, so both derivatives start from zero history
  task automatic test_first_tick_after_reset();
    gain_vec_t g;
    g = '0;
    g[REG_OUTER_PROP]  = GAIN_ONE;
    g[REG_OUTER_INTEG] = 16'h0040;
    g[REG_OUTER_DERIV] = 16'h0080;
    g[REG_INNER_PROP]  = GAIN_ONE;
    g[REG_INNER_DERIV] = 16'h0200;
    load_gains(g);
    send_paced(make_tick(100, 50, 300));
    send_paced(make_tick(100, -20, 280));
    send_paced(make_tick(-7, 0, -7));
    wait_results_drained();
  endtask

  // writes to indexes past the register file must leave the gains alone
  task automatic test_unknown_register_index();
    wait_results_drained();
    cfg_write(REG_SPARE_LO, GAIN_MAX);
    cfg_write(REG_SPARE_MID, GAIN_MIN);
    cfg_write(REG_SPARE_HI, 16'hFFFF);
    cfg_valid <= 1'b0;
    send_paced(make_tick(10, 5, 40));
    send_paced(make_tick(-300, 100, 200));
    wait_results_drained();
  endtask

  // unity integral path only: the drive is the integral itself, plus the rate feed where a rate is given
  task automatic test_integral_clamp();
    gain_vec_t g;
    g = '0;
    g[REG_OUTER_INTEG] = GAIN_ONE;
    g[REG_INNER_PROP]  = GAIN_ONE;
    load_gains(g);
    send_paced(make_tick(-32768, 0, 32767));   // full positive error, clamps high
    send_paced(make_tick(0, 0, 500));
    send_paced(make_tick(32767, 0, -32768));   // full negative error, clamps low
    send_paced(make_tick(0, 0, 0));
    send_paced(make_tick(0, 0, 250));
    send_paced(make_tick(0, 32767, 0));        // rate feed pushes past the limit
    send_paced(make_tick(0, -32768, 0));
    wait_results_drained();
  endtask

  // extreme gains with extreme fields, saturation on both sides
  task automatic test_drive_saturation();
    gain_vec_t g;
    g = {NUM_REGS{GAIN_MAX}};
    load_gains(g);
    send_paced(make_tick(-32768, 32767, 32767));
    send_paced(make_tick(32767, -32768, -32768));
    send_paced(make_tick(0, 0, 0));
    g = {NUM_REGS{GAIN_MIN}};
    load_gains(g);
    send_paced(make_tick(-32768, 32767, 32767));
    send_paced(make_tick(32767, -32768, -32768));
    send_paced(make_tick(-1, -1, -1));
    g = '0;
    load_gains(g);
    send_paced(make_tick(-32768, -32768, 32767));
    wait_results_drained();
  endtask

  // several gain settings, mostly tracking trajectories with full-range noise mixed in
  task automatic test_random_tracking();
    gain_vec_t g;
    for (int p = 0; p < RAND_PHASES; p++) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        case (p)
          0:       g[r] = GAIN_MAX;
          1:       g[r] = GAIN_MIN;
          2:       g[r] = '0;
          3:       g[r] = $urandom_range(1) ? GAIN_MAX : GAIN_MIN;
          4:       g[r] = DATA_W'($urandom);
          default: g[r] = DATA_W'(int'($urandom_range(1024)) - 512);
        endcase
      end
      load_gains(g);
      sender_steady = (p % 4 == 2);
      for (int n = 0; n < PHASE_TICKS; n++) begin
        // sender holds off until the block has caught up completely
        if (p == 5 && n == PHASE_TICKS / 2) wait_results_drained();
        if ($urandom_range(9) < 7) send_paced(tracking_tick());
        else send_paced(random_tick());
      end
    end
    sender_steady = 1'b0;
    wait_results_drained();
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_tick_after_reset();
    test_unknown_register_index();
    test_integral_clamp();
    test_drive_saturation();
    test_random_tracking();

    wait_results_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (pending_drive_q.size() != 0) begin
      mismatches += pending_drive_q.size();
      $display("%0d drive values never came back", pending_drive_q.size());
    end

    $display("summary: %0d ticks under %0d gain settings, %0d drive beats checked",
             ticks_sent, gain_settings, drives_checked);
    $display("summary: first tick, spare indexes, integral clamp, saturation, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("tb_cascade_angle_rate_pid_top: done, clean");
    end else begin
      $display("tb_cascade_angle_rate_pid_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
